// ----- src/hyper_connection_post_mixer_top_macros.svh -----
// ----------------------------------------------------------------------------
// hyper connection post mixer assertion macros
// shared property forms for the top level checks
// ----------------------------------------------------------------------------
`ifndef HYPER_CONNECTION_POST_MIXER_TOP_MACROS_SVH
`define HYPER_CONNECTION_POST_MIXER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// consequent holds in the cycle after the antecedent
`define HCPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcpm check failed");
// consequent holds in the same cycle
`define HCPM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcpm check failed");
`else
`define HCPM_ASSERT_NEXT(lbl, ante, cons)
`define HCPM_ASSERT_SAME(lbl, ante, cons)
`endif

`endif

// ----- src/hcpm_pkg.sv -----
// ----------------------------------------------------------------------------
// hcpm_pkg
// constants, types, fp32 normalize / round and bf16 helpers of the post mixer
// ----------------------------------------------------------------------------
package hcpm_pkg;

    localparam int STREAMS    = 4;
    localparam int LANES      = 4;
    localparam int NS         = (STREAMS < 1) ? 1 : ((STREAMS < LANES) ? STREAMS : LANES);
    localparam int GAIN_SLOTS = 8;
    localparam int TERMS      = LANES + 1;
    localparam int ADD_LAT    = 4;
    localparam int MUL_LAT    = 3;
    localparam int PIPE_LAT   = MUL_LAT + TERMS * ADD_LAT;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // value = m / 2^47 * 2^(x - 127)
    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic signed [11:0] x;
        logic        [47:0] m;
    } t_pre;

    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic               right;
        logic         [5:0] amt;
        logic signed [11:0] e;
        logic        [47:0] m;
    } t_norm;

    function automatic t_norm f_prep(input t_pre p);
        t_norm              n;
        logic         [5:0] lz;
        logic signed [11:0] xn;
        logic signed [11:0] rs;
        lz = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (p.m[i]) lz = 6'(47 - i);
        end
        n.sign = p.sign;
        n.nan  = p.nan;
        n.inf  = p.inf;
        n.zero = (p.m == 48'd0);
        n.m    = p.m;
        xn     = p.x - $signed({6'd0, lz});
        rs     = 12'sd1 - p.x;
        if (xn >= 12'sd1) begin
            n.right = 1'b0;
            n.amt   = lz;
            n.e     = xn;
        end else if (p.x >= 12'sd1) begin
            // lands in the subnormal range
            n.right = 1'b0;
            n.amt   = 6'(p.x - 12'sd1);
            n.e     = 12'sd1;
        end else begin
            n.right = 1'b1;
            n.amt   = (rs > 12'sd63) ? 6'd63 : 6'(rs);
            n.e     = 12'sd1;
        end
        return n;
    endfunction

    function automatic logic [31:0] f_round(input t_norm n);
        logic        [47:0] mm;
        logic        [47:0] msk;
        logic               st;
        logic               up;
        logic        [24:0] s25;
        logic        [23:0] mt;
        logic signed [11:0] e;
        if (n.right) begin
            mm  = n.m >> n.amt;
            msk = ~(48'hFFFF_FFFF_FFFF << n.amt);
            st  = |(n.m & msk);
        end else begin
            mm  = n.m << n.amt;
            msk = 48'd0;
            st  = 1'b0;
        end
        mt  = mm[47:24];
        st  = st | (|mm[22:0]);
        up  = mm[23] & (st | mt[0]);
        s25 = {1'b0, mt} + {24'd0, up};
        e   = n.e;
        if (s25[24]) begin
            mt = s25[24:1];
            e  = e + 12'sd1;
        end else begin
            mt = s25[23:0];
        end
        if (n.nan) return 32'h7FC0_0000;
        if (n.inf) return {n.sign, 8'hFF, 23'd0};
        if (n.zero) return {n.sign, 31'd0};
        if (e >= 12'sd255) return {n.sign, 8'hFF, 23'd0};
        return {n.sign, (mt[23] ? e[7:0] : 8'd0), mt[22:0]};
    endfunction

    function automatic logic [15:0] f_bf16(input logic [31:0] b);
        logic [31:0] r;
        r = b + 32'h0000_7FFF + {31'd0, b[16]};
        if ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) return 16'h7FC0;
        return r[31:16];
    endfunction

endpackage

// ----- src/hcpm_fmul.sv -----
// ----------------------------------------------------------------------------
// hcpm_fmul
// fp32 multiplier, three stages: product, normalize count, round and pack
// ----------------------------------------------------------------------------
module hcpm_fmul
    import hcpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    t_pre        r_s1, n_s1;
    t_norm       r_s2;
    logic [31:0] r_s3;

    logic [7:0]  w_ea, w_eb, w_xa, w_xb;
    logic        w_nan_a, w_nan_b, w_inf_a, w_inf_b, w_zer_a, w_zer_b;

    always_comb begin
        w_ea    = i_a[30:23];
        w_eb    = i_b[30:23];
        w_xa    = (w_ea == 8'd0) ? 8'd1 : w_ea;
        w_xb    = (w_eb == 8'd0) ? 8'd1 : w_eb;
        w_nan_a = (w_ea == 8'hFF) && (i_a[22:0] != 23'd0);
        w_nan_b = (w_eb == 8'hFF) && (i_b[22:0] != 23'd0);
        w_inf_a = (w_ea == 8'hFF) && (i_a[22:0] == 23'd0);
        w_inf_b = (w_eb == 8'hFF) && (i_b[22:0] == 23'd0);
        w_zer_a = (i_a[30:0] == 31'd0);
        w_zer_b = (i_b[30:0] == 31'd0);
        n_s1.sign = i_a[31] ^ i_b[31];
        n_s1.nan  = w_nan_a | w_nan_b | (w_inf_a & w_zer_b) | (w_zer_a & w_inf_b);
        n_s1.inf  = w_inf_a | w_inf_b;
        n_s1.x    = $signed({4'd0, w_xa}) + $signed({4'd0, w_xb}) - 12'sd126;
        n_s1.m    = {24'd0, (w_ea != 8'd0), i_a[22:0]} * {24'd0, (w_eb != 8'd0), i_b[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= f_prep(r_s1);
            r_s3 <= f_round(r_s2);
        end
    end

    assign o_p = r_s3;

endmodule

// ----- src/hcpm_fadd.sv -----
// ----------------------------------------------------------------------------
// hcpm_fadd
// fp32 adder, four stages: order, align and add, normalize count, round
// ----------------------------------------------------------------------------
module hcpm_fadd
    import hcpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);

    typedef struct packed {
        logic        sign;
        logic        sub;
        logic        zsign;
        logic        nan;
        logic        inf;
        logic        isign;
        logic [23:0] mbig;
        logic [23:0] msml;
        logic  [7:0] ebig;
        logic  [4:0] d;
    } t_align;

    t_align      r_s1, n_s1;
    t_pre        r_s2, n_s2;
    t_norm       r_s3;
    logic [31:0] r_s4;

    logic [31:0] w_big, w_sml;
    logic [7:0]  w_xb, w_xs, w_dd;
    logic        w_nan_a, w_nan_b, w_inf_a, w_inf_b;
    logic [26:0] w_mb, w_ms, w_sh, w_msk;
    logic [27:0] w_sum;

    always_comb begin
        w_nan_a = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        w_nan_b = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        w_inf_a = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        w_inf_b = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        if (i_a[30:0] >= i_b[30:0]) begin
            w_big = i_a;
            w_sml = i_b;
        end else begin
            w_big = i_b;
            w_sml = i_a;
        end
        w_xb = (w_big[30:23] == 8'd0) ? 8'd1 : w_big[30:23];
        w_xs = (w_sml[30:23] == 8'd0) ? 8'd1 : w_sml[30:23];
        w_dd = w_xb - w_xs;
        n_s1.sign  = w_big[31];
        n_s1.sub   = i_a[31] ^ i_b[31];
        n_s1.zsign = i_a[31] & i_b[31];
        n_s1.nan   = w_nan_a | w_nan_b | (w_inf_a & w_inf_b & (i_a[31] ^ i_b[31]));
        n_s1.inf   = w_inf_a | w_inf_b;
        n_s1.isign = w_inf_a ? i_a[31] : i_b[31];
        n_s1.mbig  = {(w_big[30:23] != 8'd0), w_big[22:0]};
        n_s1.msml  = {(w_sml[30:23] != 8'd0), w_sml[22:0]};
        n_s1.ebig  = w_xb;
        n_s1.d     = (w_dd > 8'd31) ? 5'd31 : w_dd[4:0];
    end

    // three extra bits below the lsb, sticky folded into the lowest
    always_comb begin
        w_mb  = {r_s1.mbig, 3'b000};
        w_ms  = {r_s1.msml, 3'b000};
        w_sh  = w_ms >> r_s1.d;
        w_msk = ~(27'h7FF_FFFF << r_s1.d);
        w_sh  = w_sh | {26'd0, |(w_ms & w_msk)};
        if (r_s1.sub) begin
            w_sum = {1'b0, w_mb} - {1'b0, w_sh};
        end else begin
            w_sum = {1'b0, w_mb} + {1'b0, w_sh};
        end
        n_s2.nan = r_s1.nan;
        n_s2.inf = r_s1.inf;
        if (r_s1.inf) begin
            n_s2.sign = r_s1.isign;
        end else if (w_sum == 28'd0) begin
            n_s2.sign = r_s1.zsign;
        end else begin
            n_s2.sign = r_s1.sign;
        end
        n_s2.x = $signed({4'd0, r_s1.ebig}) + 12'sd1;
        n_s2.m = {w_sum, 20'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= f_prep(r_s2);
            r_s4 <= f_round(r_s3);
        end
    end

    assign o_s = r_s4;

endmodule

// ----- src/hyper_connection_post_mixer_top.sv -----
// ----------------------------------------------------------------------------
// hyper_connection_post_mixer_top
// per position stream mixing with post gain, fp32 arithmetic, bf16 results
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  req_type, coef_*, branch, residual_s0..3, eot
// output    out        o_valid / i_stall  mixed_s0..3, token_done
//
// one item per cycle unless i_stall freezes the pipeline; a data item's result is valid once it has
// passed 24 register stages: 3 multiplier, five chained 4-stage adders, one output register
// coefficient loads take effect for the next item and produce no result
// i_stall on a waiting result freezes the whole pipeline, nothing is lost
// reset clears only the valid bits; coefficients hold garbage until loaded
// ----------------------------------------------------------------------------
`include "hyper_connection_post_mixer_top_macros.svh"

module hyper_connection_post_mixer_top
    import hcpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [6:0]  i_coef_index,
    input  logic [31:0] i_coef_value,
    input  logic [31:0] i_branch_value,
    input  logic [31:0] i_residual_s0,
    input  logic [31:0] i_residual_s1,
    input  logic [31:0] i_residual_s2,
    input  logic [31:0] i_residual_s3,
    input  logic        i_end_of_token,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_mixed_s0,
    output logic [15:0] o_mixed_s1,
    output logic [15:0] o_mixed_s2,
    output logic [15:0] o_mixed_s3,
    output logic        o_token_done
);

    logic        w_en, w_acc;
    logic [31:0] w_res [LANES];
    logic [31:0] w_lane [LANES];

    logic [31:0] r_gain [NS];
    logic [31:0] r_mix  [NS*NS];
    logic        r_vld  [PIPE_LAT];
    logic        r_tok  [PIPE_LAT];
    logic        r_ov;
    logic        r_otok;
    logic [15:0] r_omix [LANES];

    assign w_en    = !(r_ov && i_stall);
    assign o_stall = !w_en;
    assign w_acc   = i_valid && w_en;

    assign w_res[0] = i_residual_s0;
    assign w_res[1] = i_residual_s1;
    assign w_res[2] = i_residual_s2;
    assign w_res[3] = i_residual_s3;

    // coefficient loads, out of range slots dropped
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req_type == REQ_LOAD)) begin
            for (int j = 0; j < NS; j++) begin
                if (i_coef_index == 7'(j)) r_gain[j] <= i_coef_value;
            end
            for (int j = 0; j < NS * NS; j++) begin
                if (i_coef_index == 7'(GAIN_SLOTS + j)) r_mix[j] <= i_coef_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PIPE_LAT; j++) r_vld[j] <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= w_acc && (i_req_type == REQ_DATA);
            for (int j = 1; j < PIPE_LAT; j++) r_vld[j] <= r_vld[j-1];
            r_ov <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tok[0] <= i_end_of_token;
            for (int j = 1; j < PIPE_LAT; j++) r_tok[j] <= r_tok[j-1];
            r_otok <= r_tok[PIPE_LAT-1];
            for (int j = 0; j < LANES; j++) r_omix[j] <= f_bf16(w_lane[j]);
        end
    end

    for (genvar o = 0; o < LANES; o++) begin : g_lane
        if (o < NS) begin : g_on
            logic [31:0] w_prod [TERMS];
            logic [31:0] w_dprod [TERMS];
            logic [31:0] w_sum [TERMS];

            for (genvar k = 0; k < TERMS; k++) begin : g_term
                // last term is the post gain times the branch value
                if (k == LANES) begin : g_gain
                    hcpm_fmul u_mul (
                        .i_clk (i_clk),
                        .i_en  (w_en),
                        .i_a   (r_gain[o]),
                        .i_b   (i_branch_value),
                        .o_p   (w_prod[k])
                    );
                end else if (k < NS) begin : g_mixc
                    hcpm_fmul u_mul (
                        .i_clk (i_clk),
                        .i_en  (w_en),
                        .i_a   (r_mix[k*NS+o]),
                        .i_b   (w_res[k]),
                        .o_p   (w_prod[k])
                    );
                end else begin : g_zero
                    // stream beyond the count adds +0, which leaves the sum alone
                    assign w_prod[k] = 32'd0;
                end

                if (k == 0) begin : g_nodly
                    assign w_dprod[k] = w_prod[k];
                end else begin : g_dly
                    logic [31:0] r_dl [ADD_LAT*k];
                    always_ff @(posedge i_clk) begin
                        if (w_en) begin
                            r_dl[0] <= w_prod[k];
                            for (int j = 1; j < ADD_LAT * k; j++) r_dl[j] <= r_dl[j-1];
                        end
                    end
                    assign w_dprod[k] = r_dl[ADD_LAT*k-1];
                end

                hcpm_fadd u_add (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_a   ((k == 0) ? 32'd0 : w_sum[(k == 0) ? 0 : k-1]),
                    .i_b   (w_dprod[k]),
                    .o_s   (w_sum[k])
                );
            end
            assign w_lane[o] = w_sum[TERMS-1];
        end else begin : g_off
            // bf16 of +0 is 0
            assign w_lane[o] = 32'd0;
        end
    end

    assign o_valid      = r_ov;
    assign o_token_done = r_otok;
    assign o_mixed_s0   = r_omix[0];
    assign o_mixed_s1   = r_omix[1];
    assign o_mixed_s2   = r_omix[2];
    assign o_mixed_s3   = r_omix[3];

    `HCPM_ASSERT_NEXT(a_hold_result, o_valid && i_stall, o_valid)
    `HCPM_ASSERT_NEXT(a_load_no_item, i_valid && !o_stall && (i_req_type == REQ_LOAD), !r_vld[0])
    `HCPM_ASSERT_NEXT(a_tail_out, r_vld[PIPE_LAT-1] && !o_stall, o_valid)
    `HCPM_ASSERT_SAME(a_free_when_empty, !o_valid, !o_stall)

endmodule
